/* src/ordered_list_append_delete_key_defines.svh */
// Assertion macros used by the port checker of the ordered list block.
`ifndef ORDERED_LIST_APPEND_DELETE_KEY_DEFINES_SVH
`define ORDERED_LIST_APPEND_DELETE_KEY_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OLADK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oladk assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OLADK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oladk assertion failed");

`endif

/* src/oladk_pkg.sv */
// Package: request and status codes, controller states and control structs.
package oladk_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_LISTED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

  typedef struct packed {
    logic    ld_key;
    logic    clr_ptr;
    logic    inc_ptr;
    logic    rd_en;
    logic    rd_next;
    logic    wr_en;
    logic    wr_tail;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    status_e status;
    logic    use_rdata;
    logic    last;
  } ctl_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic ptr_end;
    logic next_end;
    logic match;
  } sts_t;

endpackage

/* src/oladk_ctrl.sv */
// Controller: sequences append, search-and-shift delete and dump over the datapath.
module oladk_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        req_type_i,
  input  oladk_pkg::sts_t   sts_i,
  output logic              busy_o,
  output oladk_pkg::ctl_t   ctl_o
);

  oladk_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oladk_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != oladk_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      oladk_pkg::S_IDLE: begin
        if (start_i) begin
          case (req_type_i)
            oladk_pkg::REQ_APPEND: state_d = oladk_pkg::S_APPEND;
            oladk_pkg::REQ_DELETE: state_d = oladk_pkg::S_SRCH_RD;
            oladk_pkg::REQ_DUMP: begin
              if (!sts_i.cnt_zero) begin
                state_d = oladk_pkg::S_DUMP_RD;
              end
            end
            default: state_d = oladk_pkg::S_IDLE;
          endcase
        end
      end
      oladk_pkg::S_APPEND:   state_d = oladk_pkg::S_IDLE;
      oladk_pkg::S_SRCH_RD: begin
        state_d = sts_i.ptr_end ? oladk_pkg::S_IDLE : oladk_pkg::S_SRCH_CMP;
      end
      oladk_pkg::S_SRCH_CMP: begin
        state_d = sts_i.match ? oladk_pkg::S_SHIFT_RD : oladk_pkg::S_SRCH_RD;
      end
      oladk_pkg::S_SHIFT_RD: begin
        state_d = sts_i.next_end ? oladk_pkg::S_IDLE : oladk_pkg::S_SHIFT_WR;
      end
      oladk_pkg::S_SHIFT_WR: state_d = oladk_pkg::S_SHIFT_RD;
      oladk_pkg::S_DUMP_RD:  state_d = oladk_pkg::S_DUMP_OUT;
      oladk_pkg::S_DUMP_OUT: begin
        state_d = sts_i.next_end ? oladk_pkg::S_IDLE : oladk_pkg::S_DUMP_RD;
      end
      default: state_d = oladk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    ctl_o.status = oladk_pkg::ST_OK;
    case (state_q)
      oladk_pkg::S_IDLE: begin
        if (start_i) begin
          ctl_o.ld_key  = 1'b1;
          ctl_o.clr_ptr = 1'b1;
          if ((req_type_i == oladk_pkg::REQ_DUMP) && sts_i.cnt_zero) begin
            ctl_o.emit   = 1'b1;
            ctl_o.status = oladk_pkg::ST_EMPTY;
            ctl_o.last   = 1'b1;
          end
        end
      end
      oladk_pkg::S_APPEND: begin
        ctl_o.emit = 1'b1;
        ctl_o.last = 1'b1;
        if (sts_i.full) begin
          ctl_o.status = oladk_pkg::ST_FULL;
        end else begin
          ctl_o.wr_en   = 1'b1;
          ctl_o.wr_tail = 1'b1;
          ctl_o.cnt_inc = 1'b1;
        end
      end
      oladk_pkg::S_SRCH_RD: begin
        if (sts_i.ptr_end) begin
          ctl_o.emit   = 1'b1;
          ctl_o.status = oladk_pkg::ST_NOT_FOUND;
          ctl_o.last   = 1'b1;
        end else begin
          ctl_o.rd_en = 1'b1;
        end
      end
      oladk_pkg::S_SRCH_CMP: begin
        ctl_o.inc_ptr = !sts_i.match;
      end
      oladk_pkg::S_SHIFT_RD: begin
        if (sts_i.next_end) begin
          ctl_o.cnt_dec = 1'b1;
          ctl_o.emit    = 1'b1;
          ctl_o.last    = 1'b1;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_next = 1'b1;
        end
      end
      oladk_pkg::S_SHIFT_WR: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.inc_ptr = 1'b1;
      end
      oladk_pkg::S_DUMP_RD: begin
        ctl_o.rd_en = 1'b1;
      end
      oladk_pkg::S_DUMP_OUT: begin
        ctl_o.emit      = 1'b1;
        ctl_o.status    = oladk_pkg::ST_LISTED;
        ctl_o.use_rdata = 1'b1;
        ctl_o.last      = sts_i.next_end;
        ctl_o.inc_ptr   = 1'b1;
      end
      default: ctl_o = '0;
    endcase
  end

endmodule

/* src/oladk_dp.sv */
// Datapath: entry memory, count, walk pointer, key and result registers.
module oladk_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] value_i,
  input  oladk_pkg::ctl_t    ctl_i,
  output oladk_pkg::sts_t    sts_o,
  output logic               strobe_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] entry_value_o,
  output logic               last_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rdata_q;
  logic [31:0]   key_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW:0]   ptr_p1;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata;
  logic          res_valid_q;
  logic [2:0]    res_status_q;
  logic [31:0]   res_value_q;
  logic          res_last_q;

  assign ptr_p1 = {1'b0, ptr_q} + 1'b1;
  assign raddr  = ctl_i.rd_next ? ptr_p1[AW-1:0] : ptr_q[AW-1:0];
  assign waddr  = ctl_i.wr_tail ? count_q[AW-1:0] : ptr_q[AW-1:0];
  assign wdata  = ctl_i.wr_tail ? key_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    if (ctl_i.ld_key) begin
      key_q <= value_i;
    end
    if (ctl_i.emit) begin
      res_status_q <= ctl_i.status;
      res_value_q  <= ctl_i.use_rdata ? rdata_q : '0;
      res_last_q   <= ctl_i.last;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (ctl_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
    ptr_d = ptr_q;
    if (ctl_i.clr_ptr) begin
      ptr_d = '0;
    end else if (ctl_i.inc_ptr) begin
      ptr_d = ptr_p1[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      res_valid_q <= ctl_i.emit;
    end
  end

  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.full     = (count_q == DepthC);
  assign sts_o.ptr_end  = (ptr_q == count_q);
  assign sts_o.next_end = (ptr_p1 == {1'b0, count_q});
  assign sts_o.match    = (rdata_q == key_q);

  assign strobe_o      = res_valid_q;
  assign status_o      = res_status_q;
  assign entry_value_o = res_value_q;
  assign last_o        = res_last_q;

endmodule

/* src/ordered_list_append_delete_key.sv */
// Bounded ordered list of signed values: append, delete first match, dump.
// A delete searches from the head and then shifts the later entries down; a dump
// shows the entries in order, and an empty list gives a single ST_EMPTY item.
// One request at a time: a new one is taken only while busy_o is low.
// Reset: asynchronous, active low; empties the list, entries are not cleared.
// Results cannot be stalled: each is shown for one cycle under strobe_o.
module ordered_list_append_delete_key #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  output logic               strobe_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] entry_value_o,
  output logic               last_o
);

  oladk_pkg::ctl_t ctl;
  oladk_pkg::sts_t sts;

  oladk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .busy_o     (busy_o),
    .ctl_o      (ctl)
  );

  oladk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .strobe_o      (strobe_o),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .last_o        (last_o)
  );

endmodule

/* src/oladk_chk.sv */
// Port checker for the ordered list block, bound to the top level.
`include "ordered_list_append_delete_key_defines.svh"

module oladk_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [1:0]         req_type_i,
  input logic signed [31:0] value_i,
  input logic               strobe_o,
  input logic [2:0]         status_o,
  input logic signed [31:0] entry_value_o,
  input logic               last_o
);

  `OLADK_ASSERT_NOW(a_value_zero, strobe_o && (status_o != oladk_pkg::ST_LISTED), entry_value_o == '0)
  `OLADK_ASSERT_NOW(a_single_last, strobe_o && (status_o != oladk_pkg::ST_LISTED), last_o)
  `OLADK_ASSERT_NOW(a_more_listed, strobe_o && !last_o, status_o == oladk_pkg::ST_LISTED)
  `OLADK_ASSERT_NEXT(a_busy_after, start_i && !busy_o && ((req_type_i == oladk_pkg::REQ_APPEND) || (req_type_i == oladk_pkg::REQ_DELETE)), busy_o)

endmodule

bind ordered_list_append_delete_key oladk_chk u_oladk_chk (.*);

/* tb/ordered_list_append_delete_key_checker.sv */
// Checker for the ordered list: tracks the held entries and compares every result item.
module ordered_list_append_delete_key_checker #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  logic               strobe_o,
  input  logic [2:0]         status_o,
  input  logic signed [31:0] entry_value_o,
  input  logic               last_o,
  output int                 error_count_o,
  output int                 outstanding_o
);

  typedef struct {
    oladk_pkg::status_e status;
    logic signed [31:0] value;
    logic               last;
  } answer_t;

  answer_t            answers_q[$];
  logic signed [31:0] held_q[$];

  initial begin
    error_count_o = 0;
    outstanding_o = 0;
  end

  task automatic update_list_and_answer(input logic [1:0] req, input logic signed [31:0] key);
    int pos;
    pos = -1;
    case (req)
      oladk_pkg::REQ_APPEND: begin
        if (held_q.size() >= DEPTH) begin
          answers_q.push_back('{oladk_pkg::ST_FULL, 32'sd0, 1'b1});
        end else begin
          held_q.push_back(key);
          answers_q.push_back('{oladk_pkg::ST_OK, 32'sd0, 1'b1});
        end
      end
      oladk_pkg::REQ_DELETE: begin
        // first match from the head only
        foreach (held_q[i]) begin
          if (pos < 0 && held_q[i] === key) pos = i;
        end
        if (pos < 0) begin
          answers_q.push_back('{oladk_pkg::ST_NOT_FOUND, 32'sd0, 1'b1});
        end else begin
          held_q.delete(pos);
          answers_q.push_back('{oladk_pkg::ST_OK, 32'sd0, 1'b1});
        end
      end
      oladk_pkg::REQ_DUMP: begin
        if (held_q.size() == 0) begin
          answers_q.push_back('{oladk_pkg::ST_EMPTY, 32'sd0, 1'b1});
        end else begin
          foreach (held_q[i]) begin
            answers_q.push_back('{oladk_pkg::ST_LISTED, held_q[i],
                                  i == held_q.size() - 1});
          end
        end
      end
      default: ;  // unused code: no result, list unchanged
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      held_q.delete();
      answers_q.delete();
    end else begin
      if (strobe_o === 1'b1) begin
        if (answers_q.size() == 0) begin
          if (error_count_o < 10) begin
            $display("unexpected result item: status %0d value %0d last %0b",
                     status_o, entry_value_o, last_o);
          end
          error_count_o = error_count_o + 1;
        end else begin
          want = answers_q.pop_front();
          if (status_o !== want.status || entry_value_o !== want.value ||
              last_o !== want.last) begin
            if (error_count_o < 10) begin
              $display("mismatch: status %0d/%0d value %0d/%0d last %0b/%0b (exp/act)",
                       want.status, status_o, want.value, entry_value_o,
                       want.last, last_o);
            end
            error_count_o = error_count_o + 1;
          end
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        update_list_and_answer(req_type_i, value_i);
      end
    end
    outstanding_o = answers_q.size();
  end

endmodule

/* tb/ordered_list_append_delete_key_tb.sv */
// Testbench top: clock, reset, request stimulus and verdict for the ordered list.
module ordered_list_append_delete_key_tb;

  localparam int DEPTH = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [1:0]         req_type_i = oladk_pkg::REQ_APPEND;
  logic signed [31:0] value_i = 32'sd0;
  logic               busy_o;
  logic               strobe_o;
  logic [2:0]         status_o;
  logic signed [31:0] entry_value_o;
  logic               last_o;
  int                 error_count;
  int                 outstanding;

  logic signed [31:0] key_pool[8];

  always #4 clk_i = ~clk_i;

  ordered_list_append_delete_key #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .status_o     (status_o),
    .entry_value_o(entry_value_o),
    .last_o       (last_o)
  );

  ordered_list_append_delete_key_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .status_o     (status_o),
    .entry_value_o(entry_value_o),
    .last_o       (last_o),
    .error_count_o(error_count),
    .outstanding_o(outstanding)
  );

  // Drive one request after an optional idle gap; returns once the item is taken.
  task automatic issue_request(input logic [1:0] req, input logic signed [31:0] val,
                               input int gap);
    logic taken;
    if (gap > 0) begin
      start_i    <= 1'b0;
      req_type_i <= 2'($urandom);
      value_i    <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  function automatic int idle_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 9);
    if (quiet || roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int         taken_items;
    int         append_weight;
    int         roll;
    bit         quiet;
    logic [1:0] req;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, extremes, duplicates, misses, unused code, full list
    issue_request(oladk_pkg::REQ_DUMP, 32'sd0, 0);
    issue_request(oladk_pkg::REQ_DELETE, 32'sd5, 0);
    issue_request(oladk_pkg::REQ_APPEND, 32'sh8000_0000, 0);
    issue_request(oladk_pkg::REQ_APPEND, 32'sh7fff_ffff, 1);
    issue_request(oladk_pkg::REQ_APPEND, 32'sd0, 0);
    issue_request(oladk_pkg::REQ_APPEND, -32'sd1, 0);
    issue_request(oladk_pkg::REQ_APPEND, 32'sh8000_0000, 2);
    issue_request(oladk_pkg::REQ_DELETE, 32'sh8000_0000, 0);
    issue_request(oladk_pkg::REQ_DUMP, 32'sd0, 0);
    issue_request(oladk_pkg::REQ_DELETE, 32'sd12345, 0);
    issue_request(REQ_UNUSED, 32'sd7, 0);
    for (int i = 0; i < DEPTH - 3; i++) begin
      issue_request(oladk_pkg::REQ_APPEND, 32'(i * 32'h1111_1111), 0);
    end
    issue_request(oladk_pkg::REQ_DUMP, 32'sd0, 0);

    // random: blocks leaning towards filling or draining the list, or balanced
    taken_items   = 0;
    append_weight = 50;
    quiet         = 1'b0;
    while (taken_items < 260) begin
      if (taken_items % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: append_weight = 75;
          1: append_weight = 50;
          default: append_weight = 25;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        req = REQ_UNUSED;
      end else if (roll < 15) begin
        req = oladk_pkg::REQ_DUMP;
      end else if ($urandom_range(0, 99) < append_weight) begin
        req = oladk_pkg::REQ_APPEND;
      end else begin
        req = oladk_pkg::REQ_DELETE;
      end
      issue_request(req, (req == oladk_pkg::REQ_DUMP) ? $urandom : pick_key(),
                    idle_gap(quiet));
      if (req != REQ_UNUSED) taken_items++;
    end
    start_i <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 8) @(posedge clk_i);

    if (error_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/oladk_pkg.sv
src/oladk_ctrl.sv
src/oladk_dp.sv
src/ordered_list_append_delete_key.sv
src/oladk_chk.sv
tb/ordered_list_append_delete_key_checker.sv
tb/ordered_list_append_delete_key_tb.sv
